// ----- hdl/svang_pkg.sv -----
// Shared constants, sideband type and arctangent table for the vector angle pipeline.
`default_nettype none
package svang_pkg;

    localparam int COMPONENT_BITS  = 16;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int PROD_W  = 2 * COMPONENT_BITS;
    localparam int C_W     = 2 * COMPONENT_BITS + 2;
    localparam int MAG_W   = 2 * COMPONENT_BITS;
    localparam int LEN_W   = $clog2(MAG_W + 1);
    localparam int SH_W    = 7;
    localparam int TV_W    = C_W + COMPONENT_BITS;
    localparam int TSUM_W  = TV_W + 2;

    localparam int NORM_BITS  = 30;
    localparam int SQ_W       = 2 * NORM_BITS;
    localparam int RAD_W      = SQ_W + 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int ACC_FRAC     = 24;
    localparam int FIN_W        = 34;
    localparam int RND_SH       = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int RES_W        = FIN_W - RND_SH;
    localparam int OUT_W        = 17;

    // sideband that travels beside each beat
    typedef struct packed {
        logic valid;
        logic zero;
        logic flip;
        logic d_neg;
    } side_t;

    // atan(2^-i) in degrees, units of 2^-24 degree
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = Z_W'(754974720);
            5'd1:  v = Z_W'(445687602);
            5'd2:  v = Z_W'(235489088);
            5'd3:  v = Z_W'(119537938);
            5'd4:  v = Z_W'(60000934);
            5'd5:  v = Z_W'(30029717);
            5'd6:  v = Z_W'(15018523);
            5'd7:  v = Z_W'(7509720);
            5'd8:  v = Z_W'(3754917);
            5'd9:  v = Z_W'(1877466);
            5'd10: v = Z_W'(938734);
            5'd11: v = Z_W'(469367);
            5'd12: v = Z_W'(234684);
            5'd13: v = Z_W'(117342);
            5'd14: v = Z_W'(58671);
            5'd15: v = Z_W'(29335);
            5'd16: v = Z_W'(14668);
            5'd17: v = Z_W'(7334);
            5'd18: v = Z_W'(3667);
            5'd19: v = Z_W'(1833);
            5'd20: v = Z_W'(917);
            5'd21: v = Z_W'(458);
            5'd22: v = Z_W'(229);
            5'd23: v = Z_W'(115);
            5'd24: v = Z_W'(57);
            5'd25: v = Z_W'(29);
            5'd26: v = Z_W'(14);
            5'd27: v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // bit length of a magnitude word
    function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/svang_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root.
`default_nettype none
module svang_sqrt_cell
    import svang_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire side_t             side_in,
    input  wire logic [RAD_W-1:0]  rad_in,
    input  wire logic [ROOT_W-1:0] root_in,
    input  wire logic [REM_W-1:0]  rem_in,
    input  wire logic [NORM_BITS-1:0] dmag_in,
    output side_t                  side_reg,
    output logic [RAD_W-1:0]       rad_reg,
    output logic [ROOT_W-1:0]      root_reg,
    output logic [REM_W-1:0]       rem_reg,
    output logic [NORM_BITS-1:0]   dmag_reg
);

    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [ROOT_W-1:0] root_next;
    logic [REM_W-1:0]  rem_next;

    // bring down two radicand bits and try one root bit
    always_comb
    begin
        cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
        trial = (REM_W + 2)'({root_in, 2'b01});
        if (cur >= trial)
        begin
            rem_next  = REM_W'(cur - trial);
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_W'(cur);
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    // hold control on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in << 2;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            dmag_reg <= dmag_in;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/svang_cordic_cell.sv -----
// One vectoring rotation cell of the arctangent chain.
`default_nettype none
module svang_cordic_cell
    import svang_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [STEP_W-1:0]     step,
    input  wire side_t                 side_in,
    input  wire logic signed [XY_W-1:0] x_in,
    input  wire logic signed [XY_W-1:0] y_in,
    input  wire logic signed [Z_W-1:0]  z_in,
    output side_t                      side_reg,
    output logic signed [XY_W-1:0]     x_reg,
    output logic signed [XY_W-1:0]     y_reg,
    output logic signed [Z_W-1:0]      z_reg
);

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;

    // rotate toward y = 0; stop once y is zero
    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (y_in != '0)
        begin
            if (!y_in[XY_W-1])
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + atan_step(step);
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - atan_step(step);
            end
        end
    end

    // hold control on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/signed_vector_angle_3d.sv -----
// Top level: angle between two 3D integer vectors, optionally signed by a view vector.
`default_nettype none
// Fully pipelined: one vector pair per clock while not stalled; each result passes
// through 7 front stages for products, magnitudes, normalization and squares, 31 square
// root digit cells, 28 CORDIC cells and 1 output register. The whole pipeline
// advances together and halts only while a finished result sits on the output
// with out_stall high; in_stall is high exactly then. The angle is in units of
// 1/256 degree, 0 when either vector is zero, and with opcode 1 it is negated
// unless (a x b).view is strictly positive.
module signed_vector_angle_3d
    import svang_pkg::*;
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            opcode,
    input  wire logic signed [COMPONENT_BITS-1:0] a_x,
    input  wire logic signed [COMPONENT_BITS-1:0] a_y,
    input  wire logic signed [COMPONENT_BITS-1:0] a_z,
    input  wire logic signed [COMPONENT_BITS-1:0] b_x,
    input  wire logic signed [COMPONENT_BITS-1:0] b_y,
    input  wire logic signed [COMPONENT_BITS-1:0] b_z,
    input  wire logic signed [COMPONENT_BITS-1:0] view_x,
    input  wire logic signed [COMPONENT_BITS-1:0] view_y,
    input  wire logic signed [COMPONENT_BITS-1:0] view_z,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [OUT_W-1:0]              angle
);

    logic en;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] angle_reg;

    // stage valids and opcodes
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic op1_reg, op2_reg, op3_reg, op4_reg;

    // stage 1 products
    logic signed [PROD_W-1:0] p_aybz_reg, p_azby_reg, p_azbx_reg, p_axbz_reg;
    logic signed [PROD_W-1:0] p_axby_reg, p_aybx_reg;
    logic signed [PROD_W-1:0] p_axbx_reg, p_ayby_reg, p_azbz_reg;
    logic signed [COMPONENT_BITS-1:0] vx1_reg, vy1_reg, vz1_reg;
    logic signed [COMPONENT_BITS-1:0] vx2_reg, vy2_reg, vz2_reg;

    // stage 2 cross and dot
    logic signed [C_W-1:0] c0_reg, c1_reg, c2_reg, d_reg;

    // stage 3 triple terms and magnitudes
    logic signed [TV_W-1:0] tv0_reg, tv1_reg, tv2_reg;
    logic [MAG_W-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic dneg3_reg;

    // stage 4 sign test and bit length
    logic pos4_reg, zero4_reg, dneg4_reg;
    logic [LEN_W-1:0] len4_reg;
    logic [MAG_W-1:0] m0_4_reg, m1_4_reg, m2_4_reg, m3_4_reg;
    logic signed [TSUM_W-1:0] tsum;

    // stage 5 normalized magnitudes
    logic [NORM_BITS-1:0] n0_reg, n1_reg, n2_reg, n3_reg;
    logic [NORM_BITS-1:0] n0_next, n1_next, n2_next, n3_next;
    side_t side5_reg;

    // stage 6 squares
    logic [SQ_W-1:0] sq0_reg, sq1_reg, sq2_reg;
    logic [NORM_BITS-1:0] dmag6_reg;
    side_t side6_reg;

    // stage 7 radicand
    logic [RAD_W-1:0] rad7_reg;
    logic [NORM_BITS-1:0] dmag7_reg;
    side_t side7_reg;

    // pipeline advances unless a result is held
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

    // valid and opcode flow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            side5_reg <= '0;
            side6_reg <= '0;
            side7_reg <= '0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            side5_reg <= '{valid: v4_reg, zero: zero4_reg,
                           flip: op4_reg && !pos4_reg, d_neg: dneg4_reg};
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
        end
    end

    // stage 1: component products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg    <= opcode;
            p_aybz_reg <= a_y * b_z;
            p_azby_reg <= a_z * b_y;
            p_azbx_reg <= a_z * b_x;
            p_axbz_reg <= a_x * b_z;
            p_axby_reg <= a_x * b_y;
            p_aybx_reg <= a_y * b_x;
            p_axbx_reg <= a_x * b_x;
            p_ayby_reg <= a_y * b_y;
            p_azbz_reg <= a_z * b_z;
            vx1_reg    <= view_x;
            vy1_reg    <= view_y;
            vz1_reg    <= view_z;
        end
    end

    // stage 2: cross and dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg <= op1_reg;
            c0_reg  <= C_W'(p_aybz_reg) - C_W'(p_azby_reg);
            c1_reg  <= C_W'(p_azbx_reg) - C_W'(p_axbz_reg);
            c2_reg  <= C_W'(p_axby_reg) - C_W'(p_aybx_reg);
            d_reg   <= C_W'(p_axbx_reg) + C_W'(p_ayby_reg) + C_W'(p_azbz_reg);
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;
        end
    end

    // stage 3: triple product terms and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg   <= op2_reg;
            tv0_reg   <= TV_W'(c0_reg) * TV_W'(vx2_reg);
            tv1_reg   <= TV_W'(c1_reg) * TV_W'(vy2_reg);
            tv2_reg   <= TV_W'(c2_reg) * TV_W'(vz2_reg);
            m0_reg    <= MAG_W'(c0_reg[C_W-1] ? -c0_reg : c0_reg);
            m1_reg    <= MAG_W'(c1_reg[C_W-1] ? -c1_reg : c1_reg);
            m2_reg    <= MAG_W'(c2_reg[C_W-1] ? -c2_reg : c2_reg);
            m3_reg    <= MAG_W'(d_reg[C_W-1] ? -d_reg : d_reg);
            dneg3_reg <= d_reg[C_W-1];
        end
    end

    // stage 4: sign of c.view and bit length of the largest magnitude
    assign tsum = TSUM_W'(tv0_reg) + TSUM_W'(tv1_reg) + TSUM_W'(tv2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op4_reg   <= op3_reg;
            pos4_reg  <= (tsum > 0);
            len4_reg  <= bit_len(m0_reg | m1_reg | m2_reg | m3_reg);
            zero4_reg <= ((m0_reg | m1_reg | m2_reg | m3_reg) == '0);
            dneg4_reg <= dneg3_reg;
            m0_4_reg  <= m0_reg;
            m1_4_reg  <= m1_reg;
            m2_4_reg  <= m2_reg;
            m3_4_reg  <= m3_reg;
        end
    end

    // stage 5: scale all magnitudes by one power of two
    always_comb
    begin
        logic [SH_W-1:0] shr;
        logic [SH_W-1:0] shl;
        shr = SH_W'(len4_reg) - SH_W'(NORM_BITS);
        shl = SH_W'(NORM_BITS) - SH_W'(len4_reg);
        if (SH_W'(len4_reg) > SH_W'(NORM_BITS))
        begin
            n0_next = NORM_BITS'(m0_4_reg >> shr);
            n1_next = NORM_BITS'(m1_4_reg >> shr);
            n2_next = NORM_BITS'(m2_4_reg >> shr);
            n3_next = NORM_BITS'(m3_4_reg >> shr);
        end
        else
        begin
            n0_next = NORM_BITS'(m0_4_reg) << shl;
            n1_next = NORM_BITS'(m1_4_reg) << shl;
            n2_next = NORM_BITS'(m2_4_reg) << shl;
            n3_next = NORM_BITS'(m3_4_reg) << shl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg <= n0_next;
            n1_reg <= n1_next;
            n2_reg <= n2_next;
            n3_reg <= n3_next;
        end
    end

    // stage 6: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq0_reg   <= SQ_W'(n0_reg) * SQ_W'(n0_reg);
            sq1_reg   <= SQ_W'(n1_reg) * SQ_W'(n1_reg);
            sq2_reg   <= SQ_W'(n2_reg) * SQ_W'(n2_reg);
            dmag6_reg <= n3_reg;
        end
    end

    // stage 7: sum of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad7_reg  <= RAD_W'(sq0_reg) + RAD_W'(sq1_reg) + RAD_W'(sq2_reg);
            dmag7_reg <= dmag6_reg;
        end
    end

    // square root chain
    side_t                sq_side [SQRT_STEPS+1];
    logic [RAD_W-1:0]     sq_rad  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]    sq_root [SQRT_STEPS+1];
    logic [REM_W-1:0]     sq_rem  [SQRT_STEPS+1];
    logic [NORM_BITS-1:0] sq_dmag [SQRT_STEPS+1];

    assign sq_side[0] = side7_reg;
    assign sq_rad[0]  = rad7_reg;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_dmag[0] = dmag7_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        svang_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (sq_side[k]),
            .rad_in   (sq_rad[k]),
            .root_in  (sq_root[k]),
            .rem_in   (sq_rem[k]),
            .dmag_in  (sq_dmag[k]),
            .side_reg (sq_side[k+1]),
            .rad_reg  (sq_rad[k+1]),
            .root_reg (sq_root[k+1]),
            .rem_reg  (sq_rem[k+1]),
            .dmag_reg (sq_dmag[k+1])
        );
    end

    // CORDIC chain on (|d|, |c|)
    side_t                  cd_side [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_x    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cd_z    [CORDIC_STEPS+1];

    assign cd_side[0] = sq_side[SQRT_STEPS];
    assign cd_x[0]    = XY_W'(sq_dmag[SQRT_STEPS]);
    assign cd_y[0]    = XY_W'(sq_root[SQRT_STEPS]);
    assign cd_z[0]    = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        svang_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .step     (STEP_W'(k)),
            .side_in  (cd_side[k]),
            .x_in     (cd_x[k]),
            .y_in     (cd_y[k]),
            .z_in     (cd_z[k]),
            .side_reg (cd_side[k+1]),
            .x_reg    (cd_x[k+1]),
            .y_reg    (cd_y[k+1]),
            .z_reg    (cd_z[k+1])
        );
    end

    // clamp, fold into the obtuse range, round and sign
    side_t                  fin_side;
    logic signed [Z_W-1:0]  zc;
    logic [FIN_W-1:0]       zf;
    logic [RES_W-1:0]       res;
    logic [RES_W-1:0]       res_s;
    logic signed [OUT_W-1:0] angle_next;

    assign fin_side = cd_side[CORDIC_STEPS];

    always_comb
    begin
        zc = cd_z[CORDIC_STEPS];
        if (zc[Z_W-1])
        begin
            zc = '0;
        end
        else if (zc > Z_W'(90 << ACC_FRAC))
        begin
            zc = Z_W'(90 << ACC_FRAC);
        end
        if (fin_side.d_neg)
        begin
            zf = FIN_W'(64'd180 << ACC_FRAC) - FIN_W'(zc);
        end
        else
        begin
            zf = FIN_W'(zc);
        end
        res   = RES_W'((zf + FIN_W'(64'd1 << (RND_SH - 1))) >> RND_SH);
        res_s = fin_side.flip ? -res : res;
        angle_next = fin_side.zero ? '0 : OUT_W'(res_s);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

endmodule
`default_nettype wire
